// ===== src/ptbt_pkg.sv =====
// Shared types, constants and the helper function of the per-thread block tag table.
`default_nettype none

package ptbt_pkg;

    localparam int THREADS     = 2;
    localparam int THREAD_BITS = 1;
    localparam int ENTRIES     = 16;
    localparam int ID_BITS     = 8;
    localparam int CNT_W       = 8;
    localparam int RES_W       = 5;
    localparam int OCC_W       = 5;
    localparam int DEPTH_W     = 5;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 3;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(16);

    // Queue between the front and the back; the depth is a power of two so
    // the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 3'd0,
        FUNC_RELEASE = 3'd1,
        FUNC_LOOKUP  = 3'd2,
        FUNC_FLUSH   = 3'd3,
        FUNC_STALL   = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_ALLOC   = 3'd1,
        OP_RELEASE = 3'd2,
        OP_LOOKUP  = 3'd3,
        OP_FLUSH   = 3'd4,
        OP_STALL   = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_ZERO    = 3'd2,
        ST_MISSING = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef struct packed {
        op_t                    op;
        logic [THREAD_BITS-1:0] thread;
        logic [ID_BITS-1:0]     block_id;
        logic [CNT_W-1:0]       group_count;
        logic [RES_W-1:0]       reserved;
    } op_req_t;

    // True when id a is older than or equal to id b; the top bit is a wrap bit.
    function automatic logic older_or_same(input logic [ID_BITS-1:0] a,
                                           input logic [ID_BITS-1:0] b);
        logic same_wrap;
        same_wrap = (a[ID_BITS-1] == b[ID_BITS-1]);
        if (same_wrap)
        begin
            return a[ID_BITS-2:0] <= b[ID_BITS-2:0];
        end
        return a[ID_BITS-2:0] > b[ID_BITS-2:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/ptbt_req_if.sv =====
// Request channel interface of the block tag table.
`default_nettype none

interface ptbt_req_if
    import ptbt_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [THREAD_BITS-1:0]  thread;
    logic [ID_BITS-1:0]      block_id;
    logic [CNT_W-1:0]        group_count;
    logic [RES_W-1:0]        reserved;
    logic                    by_block;

    modport source (output valid, func, thread, block_id, group_count, reserved, by_block,
                    input ready);
    modport sink   (input valid, func, thread, block_id, group_count, reserved, by_block,
                    output ready);
endinterface

`default_nettype wire

// ===== src/ptbt_rsp_if.sv =====
// Result channel interface of the block tag table.
`default_nettype none

interface ptbt_rsp_if
    import ptbt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CNT_W-1:0]     count_out;
    logic                 stall_res;
    logic [STATUS_W-1:0]  status;
    logic [OCC_W-1:0]     occupancy;

    modport source (output valid, count_out, stall_res, status, occupancy, input ready);
    modport sink   (input valid, count_out, stall_res, status, occupancy, output ready);
endinterface

`default_nettype wire

// ===== src/ptbt_cfg_if.sv =====
// Configuration write channel interface of the block tag table.
`default_nettype none

interface ptbt_cfg_if
    import ptbt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [DEPTH_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== src/ptbt_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none

module ptbt_front
    import ptbt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ptbt_req_if.sink    req,
    input  wire logic   pop,
    output logic        head_valid,
    output op_req_t     head
);

    op_req_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   fill_reg, fill_next;
    op_req_t             classified;
    logic                push;

    // Decode the function code. A flush without the by-block flag and any
    // undefined code change nothing, so both become a plain no-op.
    always_comb
    begin
        classified.thread      = req.thread;
        classified.block_id    = req.block_id;
        classified.group_count = req.group_count;
        classified.reserved    = req.reserved;
        case (req.func)
            FUNC_ALLOC:   classified.op = OP_ALLOC;
            FUNC_RELEASE: classified.op = OP_RELEASE;
            FUNC_LOOKUP:  classified.op = OP_LOOKUP;
            FUNC_FLUSH:   classified.op = req.by_block ? OP_FLUSH : OP_NOP;
            FUNC_STALL:   classified.op = OP_STALL;
            default:      classified.op = OP_NOP;
        endcase
    end

    assign req.ready  = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = req.valid && req.ready;
    assign head_valid = (fill_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

`default_nettype wire

// ===== src/ptbt_back.sv =====
// Back end: holds per-thread tag tables; one queued request a cycle unless rsp stalls.
`default_nettype none

module ptbt_back
    import ptbt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ptbt_cfg_if.sink    cfg,
    input  wire logic   head_valid,
    input  op_req_t     head,
    output logic        pop,
    ptbt_rsp_if.source  rsp
);

    logic [ENTRIES-1:0]  valid_reg [THREADS];
    logic [ENTRIES-1:0]  valid_next;
    logic [ID_BITS-1:0]  id_reg    [THREADS][ENTRIES];
    logic [CNT_W-1:0]    cnt_reg   [THREADS][ENTRIES];
    logic [OCC_W-1:0]    occ_reg   [THREADS];
    logic [OCC_W-1:0]    occ_next;
    logic [DEPTH_W-1:0]  depth_limit_reg;

    logic                rsp_valid_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                stall_reg, stall_next;
    status_t             status_reg, status_next;
    logic [OCC_W-1:0]    occ_out_reg;

    logic [ENTRIES-1:0]  row_valid;
    logic [ENTRIES-1:0]  hits;
    logic [ENTRIES-1:0]  kill;
    logic [ENTRIES-1:0]  free;
    logic [ENTRIES-1:0]  pick;
    logic [CNT_W-1:0]    hit_count;
    logic                hit;
    logic                full;
    logic                do_alloc;
    logic [OCC_W:0]      demand;

    assign cfg.ready = 1'b1;
    assign pop       = head_valid && (!rsp_valid_reg || rsp.ready);

    assign row_valid = valid_reg[head.thread];

    // Parallel compare of the selected thread's row.
    always_comb
    begin
        hit_count = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hits[i] = row_valid[i] && (id_reg[head.thread][i] == head.block_id);
            kill[i] = row_valid[i] && older_or_same(head.block_id, id_reg[head.thread][i]);
            if (hits[i])
            begin
                hit_count = hit_count | cnt_reg[head.thread][i];
            end
        end
    end

    assign hit    = |hits;
    assign free   = ~row_valid;
    assign full   = ~|free;
    assign pick   = free & (~free + ENTRIES'(1));
    assign demand = {1'b0, occ_reg[head.thread]} + {1'b0, head.reserved};

    always_comb
    begin
        valid_next  = row_valid;
        occ_next    = occ_reg[head.thread];
        count_next  = '0;
        stall_next  = 1'b0;
        status_next = ST_OK;
        do_alloc    = 1'b0;
        case (head.op)
            OP_ALLOC:
            begin
                if (hit)
                begin
                    status_next = ST_DUP;
                end
                else if (head.group_count == '0)
                begin
                    status_next = ST_ZERO;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_alloc   = 1'b1;
                    valid_next = row_valid | pick;
                    occ_next   = occ_reg[head.thread] + OCC_W'(1);
                end
            end
            OP_RELEASE:
            begin
                if (hit)
                begin
                    valid_next = row_valid & ~hits;
                    occ_next   = occ_reg[head.thread] - OCC_W'(1);
                end
                else
                begin
                    status_next = ST_MISSING;
                end
            end
            OP_LOOKUP:
            begin
                if (hit)
                begin
                    count_next = hit_count;
                end
                else
                begin
                    status_next = ST_MISSING;
                end
            end
            OP_FLUSH:
            begin
                valid_next = row_valid & ~kill;
                occ_next   = occ_reg[head.thread] - OCC_W'($countones(kill));
            end
            OP_STALL:
            begin
                stall_next = (demand > {1'b0, depth_limit_reg});
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < THREADS; t++)
            begin
                valid_reg[t] <= '0;
                occ_reg[t]   <= '0;
            end
            depth_limit_reg <= DEPTH_RESET;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                depth_limit_reg <= cfg.data;
            end
            if (pop)
            begin
                valid_reg[head.thread] <= valid_next;
                occ_reg[head.thread]   <= occ_next;
                rsp_valid_reg          <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            count_reg   <= count_next;
            stall_reg   <= stall_next;
            status_reg  <= status_next;
            occ_out_reg <= occ_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (do_alloc && pick[i])
                begin
                    id_reg[head.thread][i]  <= head.block_id;
                    cnt_reg[head.thread][i] <= head.group_count;
                end
            end
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.count_out = count_reg;
    assign rsp.stall_res = stall_reg;
    assign rsp.status    = status_reg;
    assign rsp.occupancy = occ_out_reg;

endmodule

`default_nettype wire

// ===== src/per_thread_block_tag_table_unit.sv =====
// Top level of the per-thread block tag table: front end, request queue and back end.
// Each of the two hardware threads owns a 16-entry table of blocks in flight, keyed by
// block id and holding a nonzero last-group count, plus an occupancy count. A request
// allocates, releases, looks up a count, flushes every entry equal to or younger than a
// block id (only when by_block is set), or checks whether occupancy plus a reserved amount
// exceeds the configured depth limit. Every request produces exactly one response, in
// request order. The block sustains one request per cycle while responses are taken;
// the back end updates the selected thread's table for each request it pops, comparing
// all 16 entries in parallel. An accepted request is written into the queue, executed
// by the back end from the queue head and answered through the response register. A
// two-entry queue separates the front end from the back end, so a stalled response
// only holds the back end while the front end can still take requests until the queue
// fills. The depth limit is written through the configuration channel, which is always
// ready; write it only while no request is outstanding. It resets to 16.
`default_nettype none

module per_thread_block_tag_table_unit
    import ptbt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ptbt_cfg_if.sink    cfg,
    ptbt_req_if.sink    req,
    ptbt_rsp_if.source  rsp
);

    // Head of the request queue, already classified by the front end.
    logic     head_valid;
    op_req_t  head;
    logic     pop;

    ptbt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // The back end pops the head whenever its response register is free or draining.
    ptbt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire
